// ===== rtl/ndy_pkg.sv =====
// ============================================================================
// ndy_pkg
// Shared types and constants of the nibble DPCM YUV 4:1:0 decoder.
// ============================================================================
package ndy_pkg;

  // Stream and sample widths
  localparam int WORD_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int CODE_W        = 4;
  localparam int DIM_W         = 12;
  localparam int CFG_W         = 13;
  localparam int HDR_IDX_W     = 3;
  localparam int DELTA_ENTRIES = 16;
  localparam int OFFS_ENTRIES  = 4;
  localparam int PLANE_W       = 2;

  // Largest usable frame dimension; wider register values clamp to it
  localparam int MAX_DIMENSION = 4096;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd320;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd240;

  // Register indexes (address bit 2 selects the register)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Sample planes
  localparam logic [PLANE_W-1:0] PLANE_Y  = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_CB = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_CR = 2'd2;

  // Luma samples per word
  localparam logic [CFG_W-1:0] STEP_CHROMA_ROW = 13'd4;
  localparam logic [CFG_W-1:0] STEP_LUMA_ROW   = 13'd8;

  // Last header word index and last sample index of each word kind
  localparam logic [HDR_IDX_W-1:0] HDR_LAST        = 3'd7;
  localparam logic [2:0]           SIDX_LAST_CHROMA = 3'd5;
  localparam logic [2:0]           SIDX_LAST_LUMA   = 3'd7;
  localparam logic [2:0]           SIDX_CB          = 3'd4;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_OFFSETS,
    PH_PIXELS
  } ndy_phase_t;

  // Kind of queued command
  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_OFFSETS,
    CMD_PIXELS
  } ndy_kind_t;

  // One classified word, handed from front to back
  typedef struct packed {
    ndy_kind_t              kind;
    logic [HDR_IDX_W-1:0]   hdr_idx;
    logic [WORD_W-1:0]      word;
    logic                   chroma;
    logic [DIM_W-1:0]       column;
    logic [DIM_W-1:0]       row;
    logic                   frame_done;
  } ndy_cmd_t;

endpackage

// ===== rtl/ndy_front.sv =====
// ============================================================================
// ndy_front
// Accepts stream words, tracks header/offset/pixel phase and row/column
// position, and pushes one classified command per word into the queue.
// ============================================================================
module ndy_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_first,
  input  logic [ndy_pkg::WORD_W-1:0] in_word,
  input  logic [ndy_pkg::CFG_W-1:0] frame_width,
  input  logic [ndy_pkg::CFG_W-1:0] frame_height,
  input  logic                      q_full,
  output logic                      in_ready,
  output logic                      q_push,
  output ndy_pkg::ndy_cmd_t         q_cmd
);
  import ndy_pkg::*;

  localparam logic [CFG_W-1:0] MAX_DIM_C = CFG_W'(MAX_DIMENSION);

  ndy_phase_t           phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0] hidx_r, hidx_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [DIM_W-1:0]     col_r, col_nxt;

  // position as seen by this word, after a possible restart
  ndy_phase_t           phase_cur;
  logic [HDR_IDX_W-1:0] hidx_cur;
  logic [DIM_W-1:0]     row_cur;
  logic [DIM_W-1:0]     col_cur;
  logic                 chroma;
  logic [CFG_W-1:0]     eff_w, eff_h, col_adv, row_adv;
  logic                 row_end, frame_end;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // restart handling and row/frame end detection
  always_comb begin
    phase_cur = in_first ? PH_HEADER : phase_r;
    hidx_cur  = in_first ? '0 : hidx_r;
    row_cur   = in_first ? '0 : row_r;
    col_cur   = in_first ? '0 : col_r;
    chroma    = (row_cur[1:0] == 2'b00);
    eff_w     = (frame_width  > MAX_DIM_C) ? MAX_DIM_C : frame_width;
    eff_h     = (frame_height > MAX_DIM_C) ? MAX_DIM_C : frame_height;
    col_adv   = {1'b0, col_cur} + (chroma ? STEP_CHROMA_ROW : STEP_LUMA_ROW);
    row_adv   = {1'b0, row_cur} + CFG_W'(1);
    row_end   = (col_adv >= eff_w);
    frame_end = row_end && (row_adv >= eff_h);
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (q_push) begin
      phase_nxt = phase_cur;
      hidx_nxt  = hidx_cur;
      row_nxt   = row_cur;
      col_nxt   = col_cur;
      case (phase_cur)
        PH_OFFSETS: begin
          phase_nxt = PH_PIXELS;
        end
        PH_PIXELS: begin
          if (!row_end) begin
            col_nxt = col_adv[DIM_W-1:0];
          end else begin
            col_nxt = '0;
            if (frame_end) begin
              phase_nxt = PH_HEADER;
              hidx_nxt  = '0;
              row_nxt   = '0;
            end else begin
              row_nxt = row_adv[DIM_W-1:0];
              if (row_adv[1:0] == 2'b00) begin
                phase_nxt = PH_OFFSETS;
              end
            end
          end
        end
        default: begin
          // header word; an unused phase code acts as header too
          if (hidx_cur == HDR_LAST) begin
            hidx_nxt  = '0;
            row_nxt   = '0;
            col_nxt   = '0;
            phase_nxt = PH_OFFSETS;
          end else begin
            hidx_nxt  = hidx_cur + HDR_IDX_W'(1);
            phase_nxt = PH_HEADER;
          end
        end
      endcase
    end
  end

  // command for the back end
  always_comb begin
    q_cmd.hdr_idx    = hidx_cur;
    q_cmd.word       = in_word;
    q_cmd.chroma     = chroma;
    q_cmd.column     = col_cur;
    q_cmd.row        = row_cur;
    q_cmd.frame_done = frame_end;
    case (phase_cur)
      PH_OFFSETS: q_cmd.kind = CMD_OFFSETS;
      PH_PIXELS:  q_cmd.kind = CMD_PIXELS;
      default:    q_cmd.kind = CMD_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hidx_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // header index only counts while in header phase
  a_hidx_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (hidx_r != '0) |-> (phase_r == PH_HEADER))
    else $error("header index nonzero outside header phase");

  // a row position only exists while decoding pixels
  a_col_in_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r != '0) |-> (phase_r == PH_PIXELS))
    else $error("column nonzero outside pixel phase");

endmodule

// ===== rtl/ndy_queue.sv =====
// ============================================================================
// ndy_queue
// Short command queue that decouples the front classifier from the back
// sample generator.
// ============================================================================
module ndy_queue #(
  parameter int DEPTH = ndy_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ndy_pkg::ndy_cmd_t push_data,
  input  logic              pop,
  output ndy_pkg::ndy_cmd_t pop_data,
  output logic              full,
  output logic              empty
);
  import ndy_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  ndy_cmd_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/ndy_back.sv =====
// ============================================================================
// ndy_back
// Executes queued commands: loads the delta table and row offsets, and
// expands pixel words into luma and chroma samples, one per cycle unless stalled.
// ============================================================================
module ndy_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ndy_pkg::ndy_cmd_t           q_cmd,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ndy_pkg::PLANE_W-1:0] out_plane,
  output logic [ndy_pkg::DIM_W-1:0]   out_column,
  output logic [ndy_pkg::DIM_W-1:0]   out_row,
  output logic [ndy_pkg::BYTE_W-1:0]  out_value,
  output logic                        out_last_of_word,
  output logic                        out_frame_end
);
  import ndy_pkg::*;

  localparam int DIDX_W = $clog2(DELTA_ENTRIES);

  // current pixel word
  ndy_cmd_t         cur_r;
  logic             cur_valid_r;
  logic [2:0]       sidx_r;
  logic [BYTE_W-1:0] acc_r;

  // decode tables
  logic [BYTE_W-1:0] delta_r [DELTA_ENTRIES];
  logic [BYTE_W-1:0] offs_r  [OFFS_ENTRIES];

  // output register
  logic              out_valid_r;
  logic [PLANE_W-1:0] out_plane_r;
  logic [DIM_W-1:0]  out_column_r, out_row_r;
  logic [BYTE_W-1:0] out_value_r;
  logic              out_last_r, out_frame_end_r;

  logic              advance, finish, is_luma, is_first;
  logic [2:0]        sidx_last;
  logic [BYTE_W-1:0] b0, b1, b2, b3, code_byte, luma_val;
  logic [CODE_W-1:0] code;

  assign b0 = cur_r.word[7:0];
  assign b1 = cur_r.word[15:8];
  assign b2 = cur_r.word[23:16];
  assign b3 = cur_r.word[31:24];

  // sequencing of samples within a word
  always_comb begin
    sidx_last = cur_r.chroma ? SIDX_LAST_CHROMA : SIDX_LAST_LUMA;
    advance   = cur_valid_r && (!out_valid_r || out_ready);
    finish    = advance && (sidx_r == sidx_last);
    q_pop     = !q_empty && (!cur_valid_r || finish);
    is_luma   = !cur_r.chroma || !sidx_r[2];
    is_first  = (cur_r.column == '0) && (sidx_r == '0);
  end

  // nibble select: 2lo,2hi,3lo,3hi,0lo,0hi,1lo,1hi; chroma rows 2lo,2hi,0lo,0hi
  always_comb begin
    if (cur_r.chroma) begin
      code_byte = sidx_r[1] ? b0 : b2;
    end else begin
      case (sidx_r[2:1])
        2'd0:    code_byte = b2;
        2'd1:    code_byte = b3;
        2'd2:    code_byte = b0;
        default: code_byte = b1;
      endcase
    end
    code     = sidx_r[0] ? code_byte[7:4] : code_byte[3:0];
    luma_val = is_first ? offs_r[cur_r.row[1:0]] : acc_r + delta_r[code];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (q_pop && (q_cmd.kind == CMD_PIXELS)) begin
        cur_valid_r <= 1'b1;
      end else if (finish) begin
        cur_valid_r <= 1'b0;
      end
      if (finish) begin
        sidx_r <= '0;
      end else if (advance) begin
        sidx_r <= sidx_r + 3'd1;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance && is_luma) begin
        acc_r <= luma_val;
      end
    end
  end

  // current word and table loads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_cmd.kind)
        CMD_PIXELS: begin
          cur_r <= q_cmd;
        end
        CMD_OFFSETS: begin
          offs_r[0] <= q_cmd.word[7:0];
          offs_r[1] <= q_cmd.word[15:8];
          offs_r[2] <= q_cmd.word[23:16];
          offs_r[3] <= q_cmd.word[31:24];
        end
        default: begin
          delta_r[{q_cmd.hdr_idx, 1'b0}] <= q_cmd.word[7:0];
          delta_r[{q_cmd.hdr_idx, 1'b1}] <= q_cmd.word[23:16];
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_last_r      <= (sidx_r == sidx_last);
      out_frame_end_r <= (sidx_r == sidx_last) && cur_r.frame_done;
      if (is_luma) begin
        out_plane_r  <= PLANE_Y;
        out_column_r <= cur_r.column + DIM_W'(sidx_r);
        out_row_r    <= cur_r.row;
        out_value_r  <= luma_val;
      end else begin
        out_plane_r  <= (sidx_r == SIDX_CB) ? PLANE_CB : PLANE_CR;
        out_column_r <= cur_r.column >> 2;
        out_row_r    <= cur_r.row >> 2;
        out_value_r  <= (sidx_r == SIDX_CB) ? b3 : b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_plane        = out_plane_r;
  assign out_column       = out_column_r;
  assign out_row          = out_row_r;
  assign out_value        = out_value_r;
  assign out_last_of_word = out_last_r;
  assign out_frame_end    = out_frame_end_r;

  // the delta index covers the whole table
  a_delta_index: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_cmd.kind == CMD_HEADER)) |-> (DIDX_W == HDR_IDX_W + 1))
    else $error("delta table index width mismatch");

  a_sidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (sidx_r <= sidx_last))
    else $error("sample index past end of word");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_last_r)
    else $error("frame end on a sample that does not close its word");

endmodule

// ===== rtl/nibble_dpcm_yuv410_decoder.sv =====
// ============================================================================
// nibble_dpcm_yuv410_decoder
// Nibble DPCM intra frame decoder producing YUV 4:1:0 samples.
// ============================================================================
// Words of four stream bytes enter on in_*; each is classified by the front
// end (header, row offsets or pixels) and queued, and the back end turns pixel
// words into samples on out_*, one sample per cycle while out_tready allows,
// through a single output register. A pixel word in an ordinary row gives 8
// luma samples; in every fourth row, starting with row 0, it gives 4 luma, Cb
// and Cr. Header and offset words are consumed by the back end and emit nothing;
// one that sits between two pixel words leaves a gap in the samples. The queue
// holds QUEUE_DEPTH words, so the input keeps accepting while samples wait.
// frame_width (address 0) and frame_height (address 4) are read by the front
// end as each word is accepted; write them only while the block is idle.
// ============================================================================
module nibble_dpcm_yuv410_decoder #(
  parameter int QUEUE_DEPTH = ndy_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // byte0[7:0], byte1[15:8], byte2[23:16], byte3[31:24]
  input  logic [0:0]  in_tuser,   // first_word[0]
  // sample stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // column[11:0], row[23:12], sample_value[31:24]
  output logic [2:0]  out_tuser,  // plane[1:0], last_of_word[2]
  output logic        out_tlast,  // frame_end
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ndy_pkg::*;

  logic [CFG_W-1:0] frame_width_r, frame_height_r;
  logic             cfg_wr;

  logic             q_push, q_pop, q_full, q_empty;
  ndy_cmd_t         push_cmd, pop_cmd;

  logic [PLANE_W-1:0] s_plane;
  logic [DIM_W-1:0]   s_column, s_row;
  logic [BYTE_W-1:0]  s_value;
  logic               s_last, s_frame_end;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_W-1:0];
        default:          frame_width_r  <= frame_width_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FRAME_HEIGHT: cfg_prdata = {{(32-CFG_W){1'b0}}, frame_height_r};
      default:          cfg_prdata = {{(32-CFG_W){1'b0}}, frame_width_r};
    endcase
  end

  // front end: classification and position tracking
  ndy_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_first     (in_tuser[0]),
    .in_word      (in_tdata),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_full       (q_full),
    .in_ready     (in_tready),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // command queue
  ndy_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back end: sample generation
  ndy_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_cmd            (pop_cmd),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_plane        (s_plane),
    .out_column       (s_column),
    .out_row          (s_row),
    .out_value        (s_value),
    .out_last_of_word (s_last),
    .out_frame_end    (s_frame_end)
  );

  // output packing
  assign out_tdata = {s_value, s_row, s_column};
  assign out_tuser = {s_last, s_plane};
  assign out_tlast = s_frame_end;

endmodule
